@@ design/pfr_pkg.sv @@
// Shared types and constants of the page framebuffer refresh block.
`timescale 1ns / 1ps

package pfr_pkg;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               pixel_on;
        logic               refresh_after_clear;
        logic [3:0]         first_page;
        logic [4:0]         end_page;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       page_end;
        logic       refresh_done;
    } out_item_t;

    // Controller commands sent ahead of each page
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] COL_LOW_MASK  = 8'h0F;

endpackage

@@ design/page_framebuffer_refresh.sv @@
// Top level of the page framebuffer and its byte-serial refresh engine.
`timescale 1ns / 1ps

// Usage
//   Items enter on item while start is high and busy is low. Kinds: pixel
//   write, clear store, refresh a page range, and tick, which sends the next
//   byte of a running refresh.
//   A tick during a refresh gives one result on result, marked by a
//   one-cycle result_valid strobe once it has passed the stage-one and
//   result registers. Other kinds, and ticks while no refresh runs, give nothing.
//   While busy is low, pixel writes and ticks are taken one per cycle: the
//   store is read at the accepting edge and written back on the next edge,
//   with the write forwarded to a following item that reads the same byte.
//   A clear zeroes the store with a sweep of one byte per cycle, and busy
//   stays high until all PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes (1024 at
//   the defaults) are zeroed; the refresh it may request is armed at once.
//   After reset the same sweep runs, and busy is high for as long.
//   column_offset is written through cfg_valid / cfg_data; cfg_ready is
//   always high. Write it only while the block is idle.
//   The receiver cannot stall: results are shown for exactly one cycle.

module page_framebuffer_refresh #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfr_pkg::in_item_t item,
    output logic              result_valid,
    output pfr_pkg::out_item_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PAGE_W     = $clog2(PAGE_COUNT + 1);
    localparam int POS_W      = $clog2(PANEL_WIDTH + 3);

    // Configuration
    logic [7:0] col_offset_reg;

    // Refresh control
    logic              refresh_busy_reg;
    logic              refresh_busy_next;
    logic [PAGE_W-1:0] cur_page_reg;
    logic [PAGE_W-1:0] cur_page_next;
    logic [PAGE_W-1:0] stop_page_reg;
    logic [PAGE_W-1:0] stop_page_next;
    logic [POS_W-1:0]  byte_pos_reg;
    logic [POS_W-1:0]  byte_pos_next;

    // Stage one: read data arrives, modify and write back
    logic              s1_wr_reg,  s1_wr_next;
    logic              s1_out_reg, s1_out_next;
    logic [ADDR_W-1:0] s1_addr_reg, s1_addr_next;
    logic [7:0]        s1_mask_reg, s1_mask_next;
    logic              s1_on_reg,  s1_on_next;
    pfr_pkg::out_item_t s1_res_reg, s1_res_next;

    // Forwarding of the write that lands on the same edge as a read
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]        fwd_data_reg;

    // Result register
    logic               res_valid_reg, res_valid_next;
    pfr_pkg::out_item_t res_reg, res_next;

    logic              accept;
    logic              sweeping;
    logic              clear_go;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        merged;
    logic [7:0]        wr_data;

    logic              pixel_in;
    logic [PAGE_W-1:0] pixel_page;
    logic [ADDR_W-1:0] pixel_addr;
    logic [ADDR_W-1:0] tick_addr;
    logic [4:0]        end_clip;
    logic              range_ok;
    logic              tick_pend;
    logic [PAGE_W-1:0] page_inc;

    assign accept    = start && !busy;
    assign busy      = sweeping;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_offset_reg <= 8'h00;
        end
        else if (cfg_valid && cfg_ready)
        begin
            col_offset_reg <= cfg_data;
        end
    end

    // Pixel position: negative or beyond the panel is dropped
    assign pixel_in = !item.pixel_x[15] && !item.pixel_y[15]
                      && (item.pixel_x[14:0] < 15'(PANEL_WIDTH))
                      && (item.pixel_y[14:0] < 15'(PANEL_HEIGHT));
    assign pixel_page = PAGE_W'(item.pixel_y[14:3]);
    assign pixel_addr = ADDR_W'(pixel_page) * ADDR_W'(PANEL_WIDTH)
                        + ADDR_W'(item.pixel_x[14:0]);
    assign tick_addr  = ADDR_W'(cur_page_reg) * ADDR_W'(PANEL_WIDTH)
                        + ADDR_W'(byte_pos_reg - POS_W'(3));

    // Clip the range end to the page count
    assign end_clip = (item.end_page > 5'(PAGE_COUNT)) ? 5'(PAGE_COUNT) : item.end_page;
    assign range_ok = {1'b0, item.first_page} < end_clip;

    assign tick_pend = (byte_pos_reg == POS_W'(PANEL_WIDTH + 2));
    assign page_inc  = cur_page_reg + 1'b1;

    assign rd_addr  = (item.kind == pfr_pkg::KIND_TICK) ? tick_addr : pixel_addr;
    assign clear_go = accept && (item.kind == pfr_pkg::KIND_CLEAR);

    always_comb
    begin
        refresh_busy_next = refresh_busy_reg;
        cur_page_next     = cur_page_reg;
        stop_page_next    = stop_page_reg;
        byte_pos_next     = byte_pos_reg;
        s1_wr_next        = 1'b0;
        s1_out_next       = 1'b0;
        s1_addr_next      = rd_addr;
        s1_mask_next      = 8'(1) << item.pixel_y[2:0];
        s1_on_next        = item.pixel_on;
        s1_res_next       = '0;

        if (accept)
        begin
            unique case (item.kind)
                pfr_pkg::KIND_PIXEL:
                begin
                    s1_wr_next = pixel_in;
                end
                pfr_pkg::KIND_CLEAR:
                begin
                    // A full range is never empty; only a running refresh blocks it
                    if (item.refresh_after_clear && !refresh_busy_reg)
                    begin
                        refresh_busy_next = 1'b1;
                        cur_page_next     = '0;
                        stop_page_next    = PAGE_W'(PAGE_COUNT);
                        byte_pos_next     = '0;
                    end
                end
                pfr_pkg::KIND_REFRESH:
                begin
                    if (range_ok && !refresh_busy_reg)
                    begin
                        refresh_busy_next = 1'b1;
                        cur_page_next     = PAGE_W'(item.first_page);
                        stop_page_next    = PAGE_W'(end_clip);
                        byte_pos_next     = '0;
                    end
                end
                pfr_pkg::KIND_TICK:
                begin
                    if (refresh_busy_reg)
                    begin
                        s1_out_next = 1'b1;
                        // Page command, low column, high column, then data
                        if (byte_pos_reg == POS_W'(0))
                        begin
                            s1_res_next.out_byte = pfr_pkg::CMD_PAGE_BASE
                                                   + 8'(cur_page_reg[PAGE_W-1:0]);
                        end
                        else if (byte_pos_reg == POS_W'(1))
                        begin
                            s1_res_next.out_byte = col_offset_reg & pfr_pkg::COL_LOW_MASK;
                        end
                        else if (byte_pos_reg == POS_W'(2))
                        begin
                            s1_res_next.out_byte = pfr_pkg::CMD_COL_HIGH
                                                   | {4'h0, col_offset_reg[7:4]};
                        end
                        else
                        begin
                            s1_res_next.is_data = 1'b1;
                        end

                        if (tick_pend)
                        begin
                            s1_res_next.page_end = 1'b1;
                            byte_pos_next        = '0;
                            if (page_inc >= stop_page_reg)
                            begin
                                s1_res_next.refresh_done = 1'b1;
                                refresh_busy_next        = 1'b0;
                                cur_page_next            = '0;
                            end
                            else
                            begin
                                cur_page_next = page_inc;
                            end
                        end
                        else
                        begin
                            byte_pos_next = byte_pos_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    s1_out_next = 1'b0;
                end
            endcase
        end
    end

    // Take the byte just written if it is the one that was read
    assign merged  = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                      : rd_data;
    assign wr_data = s1_on_reg ? (merged | s1_mask_reg) : (merged & ~s1_mask_reg);

    always_comb
    begin
        res_valid_next = s1_out_reg;
        res_next       = s1_res_reg;
        if (s1_res_reg.is_data)
        begin
            res_next.out_byte = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_busy_reg <= 1'b0;
            cur_page_reg     <= '0;
            stop_page_reg    <= '0;
            byte_pos_reg     <= '0;
            s1_wr_reg        <= 1'b0;
            s1_out_reg       <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            refresh_busy_reg <= refresh_busy_next;
            cur_page_reg     <= cur_page_next;
            stop_page_reg    <= stop_page_next;
            byte_pos_reg     <= byte_pos_next;
            s1_wr_reg        <= s1_wr_next;
            s1_out_reg       <= s1_out_next;
            fwd_valid_reg    <= s1_wr_reg;
            res_valid_reg    <= res_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        s1_mask_reg  <= s1_mask_next;
        s1_on_reg    <= s1_on_next;
        s1_res_reg   <= s1_res_next;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= wr_data;
        res_reg      <= res_next;
    end

    pfr_store #(
        .DEPTH  (STORE_SIZE),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear_go),
        .sweeping (sweeping),
        .wr_en    (s1_wr_reg),
        .wr_addr  (s1_addr_reg),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ design/pfr_store.sv @@
// Pixel byte store: synchronous memory with a registered read and a zeroing sweep.
`timescale 1ns / 1ps

module pfr_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    output logic              sweeping,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0]        mem [DEPTH];
    logic              sweep_reg;
    logic              sweep_next;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [ADDR_W-1:0] sweep_cnt_next;
    logic [7:0]        rd_data_reg;
    logic              last_entry;

    assign last_entry = (sweep_cnt_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (sweep_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (last_entry)
            begin
                sweep_next     = 1'b0;
                sweep_cnt_next = '0;
            end
        end
        else if (clear)
        begin
            sweep_next     = 1'b1;
            sweep_cnt_next = '0;
        end
    end

    // Sweep the whole store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            mem[sweep_cnt_reg] <= 8'h00;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign sweeping = sweep_reg;
    assign rd_data  = rd_data_reg;

endmodule

@@ test/page_framebuffer_refresh_tb.sv @@
// Self-checking testbench for the page framebuffer and its refresh engine.
`timescale 1ns / 1ps

module page_framebuffer_refresh_tb;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;

    // A clear, and the sweep after reset, hold busy for a whole store pass
    // with nothing accepted; allow that several times over.
    localparam int QUIET_LIMIT  = 8 * STORE_BYTES;
    // Results leave through the stage-one and result registers after the tick; drain past that.
    localparam int DRAIN_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int PHASES          = 5;

    localparam pfr_pkg::out_item_t NO_BYTE = '0;

    // One line of the directed table; want is checked only where pin is set.
    typedef struct packed {
        pfr_pkg::kind_t     kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               on;
        logic               rac;
        logic [3:0]         fp;
        logic [4:0]         ep;
        logic               pin;
        pfr_pkg::out_item_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pfr_pkg::in_item_t  item;
    logic               result_valid;
    pfr_pkg::out_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_data;

    // Mirror of the block: pixel store, refresh position and column offset
    logic [7:0] frame [STORE_BYTES];
    bit         refresh_running;
    int         cur_page;
    int         stop_page;
    int         byte_pos;
    logic [7:0] col_offset;

    pfr_pkg::out_item_t pending_bytes [$];
    bit                 pin_valid;
    pfr_pkg::out_item_t pin_byte;
    bit                 idling_on;
    int                 mismatches;
    int                 quiet_cycles;

    // Directed part: an idle tick and empty ranges first, then the pixel edge
    // cases, then a single-page refresh with requests landing mid-way.
    stim_row_t directed_rows [27] = '{
        // tick while idle, with the spare fields set
        '{pfr_pkg::KIND_TICK, -16'sd1, -16'sd1, 1'b1, 1'b1, 4'd15, 5'd16, 1'b0, NO_BYTE},
        // empty ranges: equal bounds, clipped end, reversed, start at page count
        '{pfr_pkg::KIND_REFRESH, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd5, 5'd5, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_REFRESH, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd15, 5'd16, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_REFRESH, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd9, 5'd3, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_REFRESH, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd8, 5'd16, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        // corners of the panel, then one pixel set and cleared
        '{pfr_pkg::KIND_PIXEL, 16'sd0, 16'sd63, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sd127, 16'sd63, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sd0, 16'sd0, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sd5, 16'sd9, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sd5, 16'sd9, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        // off the panel: dropped
        '{pfr_pkg::KIND_PIXEL, -16'sd1, 16'sd63, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sd128, 16'sd63, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sd0, 16'sd64, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_PIXEL, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        // last page only, end clipped to the page count
        '{pfr_pkg::KIND_REFRESH, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd7, 5'd16, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1,
          '{8'hB7, 1'b0, 1'b0, 1'b0}},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1,
          '{8'h10, 1'b0, 1'b0, 1'b0}},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1,
          '{8'h80, 1'b1, 1'b0, 1'b0}},
        // refresh while busy: ignored
        '{pfr_pkg::KIND_REFRESH, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd8, 1'b0, NO_BYTE},
        // write ahead of the byte about to be sent
        '{pfr_pkg::KIND_PIXEL, 16'sd2, 16'sd56, 1'b1, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1,
          '{8'h01, 1'b1, 1'b0, 1'b0}},
        // clear while busy: store zeroed, its refresh ignored
        '{pfr_pkg::KIND_CLEAR, 16'sd0, 16'sd0, 1'b0, 1'b1, 4'd0, 5'd0, 1'b0, NO_BYTE},
        '{pfr_pkg::KIND_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1,
          '{8'h00, 1'b1, 1'b0, 1'b0}}
    };

    page_framebuffer_refresh #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Arm a refresh unless one runs or the clipped range is empty.
    function automatic void begin_refresh(input int first, input int last_excl);
        if (refresh_running)
            return;
        if (last_excl > PAGE_COUNT)
            last_excl = PAGE_COUNT;
        if (first >= last_excl)
            return;
        refresh_running = 1'b1;
        cur_page        = first;
        stop_page       = last_excl;
        byte_pos        = 0;
    endfunction

    // Ticks still owed to the running refresh in the mirror
    function automatic int ticks_left();
        if (!refresh_running)
            return 0;
        return (stop_page - cur_page) * (PANEL_WIDTH + 3) - byte_pos;
    endfunction

    // Advance the mirror by one accepted item; return the panel byte a tick
    // sends, if any.
    function automatic void predict_panel_byte(input pfr_pkg::in_item_t it, output bit sent,
                                               output pfr_pkg::out_item_t b);
        int         x;
        int         y;
        int         col;
        logic [7:0] mask;
        sent = 1'b0;
        b    = '0;
        case (it.kind)
            pfr_pkg::KIND_PIXEL:
            begin
                x = it.pixel_x;
                y = it.pixel_y;
                if (x >= 0 && x < PANEL_WIDTH && y >= 0 && y < PANEL_HEIGHT)
                begin
                    mask = 8'(1 << (y % 8));
                    if (it.pixel_on)
                        frame[(y / 8) * PANEL_WIDTH + x] |= mask;
                    else
                        frame[(y / 8) * PANEL_WIDTH + x] &= ~mask;
                end
            end
            pfr_pkg::KIND_CLEAR:
            begin
                foreach (frame[i])
                    frame[i] = '0;
                if (it.refresh_after_clear)
                    begin_refresh(0, PAGE_COUNT);
            end
            pfr_pkg::KIND_REFRESH:
                begin_refresh(int'(it.first_page), int'(it.end_page));
            pfr_pkg::KIND_TICK:
            begin
                if (refresh_running)
                begin
                    sent = 1'b1;
                    // three command bytes, then one data byte per column
                    if (byte_pos == 0)
                        b.out_byte = pfr_pkg::CMD_PAGE_BASE + 8'(cur_page);
                    else if (byte_pos == 1)
                        b.out_byte = col_offset & pfr_pkg::COL_LOW_MASK;
                    else if (byte_pos == 2)
                        b.out_byte = pfr_pkg::CMD_COL_HIGH | (col_offset >> 4);
                    else
                    begin
                        col          = byte_pos - 3;
                        b.out_byte   = frame[cur_page * PANEL_WIDTH + col];
                        b.is_data    = 1'b1;
                        b.page_end   = (col + 1 >= PANEL_WIDTH);
                    end
                    if (b.page_end)
                    begin
                        byte_pos = 0;
                        cur_page++;
                        if (cur_page >= stop_page)
                        begin
                            b.refresh_done  = 1'b1;
                            refresh_running = 1'b0;
                            cur_page        = 0;
                        end
                    end
                    else
                        byte_pos++;
                end
            end
        endcase
    endfunction

    // Sample on the rising edge: check the byte leaving, then mirror the item
    // entering, then any offset write.
    always @(posedge clk)
    begin
        pfr_pkg::out_item_t want;
        pfr_pkg::out_item_t fresh;
        bit                 sent;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("unexpected panel byte %0h", result.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte,
                               result.out_byte);
                        mismatches++;
                    end
                    if (result.is_data !== want.is_data)
                    begin
                        $error("is_data: expected %0b, got %0b", want.is_data,
                               result.is_data);
                        mismatches++;
                    end
                    if (result.page_end !== want.page_end)
                    begin
                        $error("page_end: expected %0b, got %0b", want.page_end,
                               result.page_end);
                        mismatches++;
                    end
                    if (result.refresh_done !== want.refresh_done)
                    begin
                        $error("refresh_done: expected %0b, got %0b", want.refresh_done,
                               result.refresh_done);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_panel_byte(item, sent, fresh);
                // a pinned row overrides the mirror with its typed-in byte
                if (pin_valid)
                    pending_bytes.push_back(pin_byte);
                else if (sent)
                    pending_bytes.push_back(fresh);
            end
            if (cfg_valid && cfg_ready)
                col_offset = cfg_data;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, so the mirror is up to date.
    task automatic send_item(input pfr_pkg::in_item_t it, input bit pin,
                             input pfr_pkg::out_item_t want);
        if (idling_on)
        begin
            while ($urandom_range(99) < 30)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        item      <= it;
        start     <= 1'b1;
        pin_valid  = pin;
        pin_byte   = want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic pfr_pkg::in_item_t tick_item();
        pfr_pkg::in_item_t it;
        logic [63:0]       raw;
        raw         = {$urandom, $urandom};
        it          = raw[$bits(pfr_pkg::in_item_t)-1:0];
        it.kind     = pfr_pkg::KIND_TICK;
        it.end_page = 5'($urandom_range(0, 16));
        return it;
    endfunction

    // Mostly well-formed: short refreshes fed with ticks, pixel writes landing
    // in between; the rest is noise, ignored requests and clears.
    function automatic pfr_pkg::in_item_t random_item();
        pfr_pkg::in_item_t it;
        int unsigned       roll;
        it   = tick_item();
        roll = $urandom_range(99);
        if (refresh_running)
        begin
            if (roll < 60)
                it.kind = pfr_pkg::KIND_TICK;
            else if (roll < 85)
                it.kind = pfr_pkg::KIND_PIXEL;
            else if (roll < 97)
                it.kind = pfr_pkg::KIND_REFRESH;
            else
                it.kind = pfr_pkg::KIND_CLEAR;
        end
        else
        begin
            if (roll < 40)
            begin
                it.kind       = pfr_pkg::KIND_REFRESH;
                it.first_page = 4'($urandom_range(0, PAGE_COUNT - 1));
                it.end_page   = 5'(it.first_page + $urandom_range(1, 2));
            end
            else if (roll < 48)
                it.kind = pfr_pkg::KIND_REFRESH;
            else if (roll < 80)
                it.kind = pfr_pkg::KIND_PIXEL;
            else if (roll < 93)
                it.kind = pfr_pkg::KIND_TICK;
            else
                it.kind = pfr_pkg::KIND_CLEAR;
        end
        // keep most pixels on the panel; the rest roam the full signed range
        if (it.kind == pfr_pkg::KIND_PIXEL && $urandom_range(99) < 85)
        begin
            it.pixel_x = 16'($urandom_range(0, PANEL_WIDTH - 1));
            it.pixel_y = 16'($urandom_range(0, PANEL_HEIGHT - 1));
        end
        return it;
    endfunction

    // Finish any refresh with ticks, then let the block go quiet.
    task automatic settle_panel();
        while (refresh_running)
            send_item(tick_item(), 1'b0, NO_BYTE);
        start     <= 1'b0;
        pin_valid  = 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_offset(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        pfr_pkg::in_item_t it;
        stim_row_t         row;
        int                counted;
        logic [7:0]        phase_offsets [PHASES];
        phase_offsets   = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h00};
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        pin_valid       = 1'b0;
        pin_byte        = '0;
        idling_on       = 1'b1;
        mismatches      = 0;
        quiet_cycles    = 0;
        refresh_running = 1'b0;
        cur_page        = 0;
        stop_page       = 0;
        byte_pos        = 0;
        col_offset      = '0;
        foreach (frame[i])
            frame[i] = '0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        // hold off until the clearing sweep after reset is over
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // Directed table, offset still at its reset value
        foreach (directed_rows[r])
        begin
            row                    = directed_rows[r];
            it                     = '0;
            it.kind                = row.kind;
            it.pixel_x             = row.x;
            it.pixel_y             = row.y;
            it.pixel_on            = row.on;
            it.refresh_after_clear = row.rac;
            it.first_page          = row.fp;
            it.end_page            = row.ep;
            send_item(it, row.pin, row.want);
        end
        settle_panel();

        // Random phases, each after a column offset write; the middle one
        // runs with no idling at all.
        for (int p = 0; p < PHASES; p++)
        begin
            write_offset((p == 3) ? 8'($urandom) : phase_offsets[p]);
            idling_on = (p != 2);
            counted   = 0;
            // every item counts, and the ticks a running refresh still owes
            // are charged to the phase up front
            while (counted + ticks_left() < ITEMS_PER_PHASE)
            begin
                it = random_item();
                counted++;
                send_item(it, 1'b0, NO_BYTE);
            end
            settle_panel();
        end

        if (pending_bytes.size() != 0)
        begin
            $error("%0d panel bytes never arrived", pending_bytes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/pfr_pkg.sv
design/pfr_store.sv
design/page_framebuffer_refresh.sv
test/page_framebuffer_refresh_tb.sv
